[hw/rtl/wsple_pkg.sv]
// Shared types and codes for the WS2812 pixel line encoder.
package wsple_pkg;

  localparam int unsigned PIXEL_DEPTH_DEF  = 256;
  localparam int unsigned CLEAR_PIXELS_DEF = 300;
  localparam int unsigned BITS_PER_PIXEL   = 24;

  // Input action codes.
  localparam logic [2:0] ACT_IDLE  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_FILL  = 3'd2;
  localparam logic [2:0] ACT_SHOW  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_LIT_COUNT       = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH_TICKS  = 3'd1;
  localparam logic [2:0] REG_ONE_LOW_TICKS   = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH_TICKS = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW_TICKS  = 3'd4;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_SHOW  = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_BAD   = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] colour;
    logic [7:0]  index;
  } item_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic       accepted;
    logic       frame_done;
  } res_t;

  typedef struct packed {
    logic [8:0] lit_count;
    logic [7:0] one_high_ticks;
    logic [7:0] one_low_ticks;
    logic [7:0] zero_high_ticks;
    logic [7:0] zero_low_ticks;
  } cfg_t;

endpackage

[hw/rtl/wsple_front.sv]
// Front end: decodes the input action and wraps the pixel index.
module wsple_front #(
  parameter int unsigned PIXEL_DEPTH = wsple_pkg::PIXEL_DEPTH_DEF
) (
  input  logic [2:0]      in_action,
  input  logic [7:0]      in_pixel_index,
  input  logic [7:0]      in_green,
  input  logic [7:0]      in_red,
  input  logic [7:0]      in_blue,
  output wsple_pkg::item_t item
);
  import wsple_pkg::*;

  // Rounded-up reciprocal of the depth; the quotient it gives is exact for any 8-bit index.
  localparam int unsigned IDX_RECIP = (PIXEL_DEPTH >= 256) ? 1
                                                           : (65536 + PIXEL_DEPTH - 1) / PIXEL_DEPTH;

  cmd_t       cmd;
  logic [7:0] idx_quo;

  always_comb begin
    unique case (in_action)
      ACT_IDLE:  cmd = CMD_IDLE;
      ACT_WRITE: cmd = CMD_WRITE;
      ACT_FILL:  cmd = CMD_FILL;
      ACT_SHOW:  cmd = CMD_SHOW;
      ACT_CLEAR: cmd = CMD_CLEAR;
      default:   cmd = CMD_BAD;
    endcase
  end

  assign idx_quo     = 8'((24'(in_pixel_index) * 24'(IDX_RECIP)) >> 16);

  assign item.cmd    = cmd;
  assign item.colour = {in_green, in_red, in_blue};
  assign item.index  = (PIXEL_DEPTH >= 256) ? in_pixel_index
                     : 8'(16'(in_pixel_index) - 16'(idx_quo) * 16'(PIXEL_DEPTH));

endmodule

[hw/rtl/wsple_queue.sv]
// Two-entry queue between the decoder and the line engine.
module wsple_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_stall,
  input  wsple_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output wsple_pkg::item_t pop_item
);
  import wsple_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_stall = (count_r == 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/wsple_back.sv]
// Line engine: pixel store, fill sweep, bit serializer and result register.
module wsple_back #(
  parameter int unsigned PIXEL_DEPTH  = wsple_pkg::PIXEL_DEPTH_DEF,
  parameter int unsigned CLEAR_PIXELS = wsple_pkg::CLEAR_PIXELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wsple_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  wsple_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output wsple_pkg::res_t  out_res
);
  import wsple_pkg::*;

  localparam int unsigned MAX_PIX = (PIXEL_DEPTH > CLEAR_PIXELS) ? PIXEL_DEPTH : CLEAR_PIXELS;
  localparam int unsigned CW      = $clog2(MAX_PIX + 1);
  localparam int unsigned AW      = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_FILL  = 4'b0010,
    MODE_SHOW  = 4'b0100,
    MODE_CLEAR = 4'b1000
  } mode_t;

  logic [23:0]   mem [PIXEL_DEPTH];
  logic [23:0]   rd_data_r;

  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] pix_cnt_r, pix_cnt_nxt;
  logic [4:0]    bit_cnt_r, bit_cnt_nxt;
  logic          phase_r, phase_nxt;
  logic [7:0]    ticks_r, ticks_nxt;
  logic [23:0]   shift_word_r, shift_word_nxt;
  logic          load_pend_r, load_pend_nxt;
  logic [23:0]   fill_col_r, fill_col_nxt;
  logic          out_valid_r;
  res_t          res_r;

  logic          fire;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0]   mem_wd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [23:0]   cur_word;
  logic [CW-1:0] frame_cnt;
  logic [CW-1:0] total;
  logic [CW:0]   pix_inc;
  logic [4:0]    bit_inc;
  logic [8:0]    ticks_inc;
  logic [7:0]    len_raw;
  logic [7:0]    len;
  logic          cur_bit;
  res_t          res;

  assign fire      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // A freshly fetched pixel sits in the read register until the first step uses it.
  assign cur_word  = load_pend_r ? rd_data_r : shift_word_r;
  assign frame_cnt = (11'(cfg.lit_count) > 11'(PIXEL_DEPTH)) ? CW'(PIXEL_DEPTH)
                                                              : CW'(cfg.lit_count);
  assign total     = (mode_r == MODE_CLEAR) ? CW'(CLEAR_PIXELS) : frame_cnt;
  assign pix_inc   = {1'b0, pix_cnt_r} + 1'b1;
  assign bit_inc   = bit_cnt_r + 5'd1;
  assign ticks_inc = {1'b0, ticks_r} + 9'd1;
  assign cur_bit   = cur_word[5'd23 - bit_cnt_r];

  always_comb begin
    if (!phase_r) begin
      len_raw = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
    end else begin
      len_raw = cur_bit ? cfg.one_low_ticks : cfg.zero_low_ticks;
    end
    len = (len_raw == 8'd0) ? 8'd1 : len_raw;
  end

  always_comb begin
    mode_nxt       = mode_r;
    pix_cnt_nxt    = pix_cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    phase_nxt      = phase_r;
    ticks_nxt      = ticks_r;
    shift_word_nxt = cur_word;
    load_pend_nxt  = 1'b0;
    fill_col_nxt   = fill_col_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = q_item.colour;
    rd_en          = 1'b0;
    rd_addr        = '0;
    res            = '0;

    unique case (mode_r)
      MODE_IDLE: begin
        case (q_item.cmd)
          CMD_IDLE: res.accepted = 1'b1;
          CMD_WRITE: begin
            res.accepted = 1'b1;
            mem_we       = 1'b1;
            mem_wa       = AW'(q_item.index);
          end
          CMD_FILL: begin
            res.accepted = 1'b1;
            if (frame_cnt == '0) begin
              res.frame_done = 1'b1;
            end else begin
              mode_nxt     = MODE_FILL;
              pix_cnt_nxt  = '0;
              fill_col_nxt = q_item.colour;
            end
          end
          CMD_SHOW: begin
            res.accepted = 1'b1;
            if (frame_cnt == '0) begin
              res.frame_done = 1'b1;
            end else begin
              mode_nxt      = MODE_SHOW;
              pix_cnt_nxt   = '0;
              bit_cnt_nxt   = '0;
              phase_nxt     = 1'b0;
              ticks_nxt     = '0;
              rd_en         = 1'b1;
              load_pend_nxt = 1'b1;
            end
          end
          CMD_CLEAR: begin
            res.accepted   = 1'b1;
            mode_nxt       = MODE_CLEAR;
            pix_cnt_nxt    = '0;
            bit_cnt_nxt    = '0;
            phase_nxt      = 1'b0;
            ticks_nxt      = '0;
            shift_word_nxt = '0;
          end
          default: res.accepted = 1'b0;
        endcase
      end
      MODE_FILL: begin
        res.accepted = (q_item.cmd == CMD_IDLE);
        mem_we       = 1'b1;
        mem_wa       = AW'(pix_cnt_r);
        mem_wd       = fill_col_r;
        if (pix_inc >= {1'b0, frame_cnt}) begin
          mode_nxt       = MODE_IDLE;
          pix_cnt_nxt    = '0;
          res.frame_done = 1'b1;
        end else begin
          pix_cnt_nxt = pix_inc[CW-1:0];
        end
      end
      MODE_SHOW, MODE_CLEAR: begin
        res.accepted   = (q_item.cmd == CMD_IDLE);
        res.line_level = !phase_r;
        if (ticks_inc >= {1'b0, len}) begin
          ticks_nxt = '0;
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            if (bit_inc >= 5'(BITS_PER_PIXEL)) begin
              bit_cnt_nxt = '0;
              if (pix_inc >= {1'b0, total}) begin
                mode_nxt       = MODE_IDLE;
                pix_cnt_nxt    = '0;
                shift_word_nxt = '0;
                res.frame_done = 1'b1;
              end else begin
                pix_cnt_nxt = pix_inc[CW-1:0];
                if (mode_r == MODE_SHOW) begin
                  // Fetch the next pixel; it is used from the next step on.
                  rd_en         = 1'b1;
                  rd_addr       = AW'(pix_inc);
                  load_pend_nxt = 1'b1;
                end else begin
                  shift_word_nxt = '0;
                end
              end
            end else begin
              bit_cnt_nxt = bit_inc;
            end
          end
        end else begin
          ticks_nxt = ticks_inc[7:0];
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase

    res.busy_res = (mode_nxt != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (fire && rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      pix_cnt_r    <= '0;
      bit_cnt_r    <= '0;
      phase_r      <= 1'b0;
      ticks_r      <= '0;
      shift_word_r <= '0;
      load_pend_r  <= 1'b0;
      fill_col_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        mode_r       <= mode_nxt;
        pix_cnt_r    <= pix_cnt_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        phase_r      <= phase_nxt;
        ticks_r      <= ticks_nxt;
        shift_word_r <= shift_word_nxt;
        load_pend_r  <= load_pend_nxt;
        fill_col_r   <= fill_col_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_done) |-> !res_r.busy_res)
    else $error("frame_done reported while still busy");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r < 5'(BITS_PER_PIXEL))
    else $error("bit counter beyond pixel width");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_FILL) |-> (pix_cnt_r < frame_cnt))
    else $error("fill sweep beyond lit count");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rd_en))
    else $error("pixel store written and read in one step");
`endif

endmodule

[hw/rtl/ws2812_pixel_line_encoder_unit.sv]
// Top level of the WS2812 pixel line encoder: ports, configuration and wiring.
//
// Each item is one clock tick of the LED data line, and the block takes one item every clock
// cycle while out_stall is low: the line engine completes one item's step (a fill entry, one
// pulse tick, a write) every cycle, and pixels for show are fetched from the single-port
// pixel store one pixel ahead of use, so the store's one read port never holds up a step.
// An item is decoded as it is accepted, waits in a two-entry queue and is processed by the
// line engine, which registers its result for the out_ side; in_stall rises only when the
// queue is full. Fill, show and clear start on the accepting item and advance on each
// following item; other actions are refused while a fill or frame is running. The pixel
// store has no reset; show must only reach pixels written earlier. cfg_ready is always high,
// and configuration is to be written only while the block is idle.
module ws2812_pixel_line_encoder_unit #(
  parameter int unsigned PIXEL_DEPTH  = wsple_pkg::PIXEL_DEPTH_DEF,
  parameter int unsigned CLEAR_PIXELS = wsple_pkg::CLEAR_PIXELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_pixel_index,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_line_level,
  output logic       out_busy_res,
  output logic       out_accepted,
  output logic       out_frame_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import wsple_pkg::*;

  cfg_t  cfg_r;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lit_count       <= 9'd256;
      cfg_r.one_high_ticks  <= 8'd16;
      cfg_r.one_low_ticks   <= 8'd9;
      cfg_r.zero_high_ticks <= 8'd8;
      cfg_r.zero_low_ticks  <= 8'd17;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIT_COUNT:       cfg_r.lit_count       <= cfg_data;
        REG_ONE_HIGH_TICKS:  cfg_r.one_high_ticks  <= cfg_data[7:0];
        REG_ONE_LOW_TICKS:   cfg_r.one_low_ticks   <= cfg_data[7:0];
        REG_ZERO_HIGH_TICKS: cfg_r.zero_high_ticks <= cfg_data[7:0];
        REG_ZERO_LOW_TICKS:  cfg_r.zero_low_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  wsple_front #(
    .PIXEL_DEPTH(PIXEL_DEPTH)
  ) u_front (
    .in_action      (in_action),
    .in_pixel_index (in_pixel_index),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_blue        (in_blue),
    .item           (in_item)
  );

  wsple_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_item   (q_item)
  );

  wsple_back #(
    .PIXEL_DEPTH  (PIXEL_DEPTH),
    .CLEAR_PIXELS (CLEAR_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_line_level = res.line_level;
  assign out_busy_res   = res.busy_res;
  assign out_accepted   = res.accepted;
  assign out_frame_done = res.frame_done;

endmodule
